// ===== src/vdit_pkg.sv =====
// vdit_pkg: shared types and constants for the vertex dedup index table
// no dependencies
package vdit_pkg;

    localparam int WORD_W    = 32;
    localparam int VERT_WORDS = 5;
    localparam int VERT_W    = WORD_W * VERT_WORDS;
    localparam int OUT_IDX_W = 8;
    localparam int IN_DATA_W = ((VERT_W + 7) / 8) * 8;

    typedef logic [VERT_W-1:0] t_vertex;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

// ===== src/vdit_vertex_mem.sv =====
// vdit_vertex_mem: unique vertex store, one write and one read port,
// registered read data; depends on vdit_pkg
module vdit_vertex_mem #(
    parameter int DEPTH = 256,
    parameter int IDX_W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_addr,
    input  vdit_pkg::t_vertex    i_wr_data,
    input  logic                 i_rd_en,
    input  logic [IDX_W-1:0]     i_rd_addr,
    output vdit_pkg::t_vertex    o_rd_data
);
    import vdit_pkg::*;

    t_vertex r_mem [DEPTH];
    t_vertex r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/vertex_dedup_index_table_unit.sv =====
// vertex_dedup_index_table_unit: vertex deduplication for index buffer builds
// depends on vdit_pkg and vdit_vertex_mem
//
// Usage:
//   slave channel: one vertex per transaction, five 32-bit attribute words
//   in tdata (word_0 lowest). master channel: one result per vertex,
//   tdata = vertex_index, tuser = {table_full, is_new}.
//   A vertex is compared against the stored unique vertices in store order,
//   one entry per cycle through the single read port of the vertex memory.
//   The first exact bit match returns its index; a miss appends the vertex
//   and returns the new index with is_new set. A miss on a full table
//   stores nothing and returns index 0 with table_full set.
//   One vertex is in the search at a time; the next is accepted the cycle
//   after the previous result is registered, so the time a vertex takes is
//   set by the sequential memory scan.
//   The result register holds while the receiver stalls; a new vertex may
//   be searched meanwhile, but its result waits until the register frees.
//   Reset empties the table (count cleared); memory contents are not cleared.
module vertex_dedup_index_table_unit #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // word_0, word_1, word_2, word_3, word_4
    input  logic [vdit_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // vertex_index
    output logic [vdit_pkg::OUT_IDX_W-1:0] o_m_axis_tdata,
    // is_new, table_full
    output logic [1:0]                     o_m_axis_tuser
);
    import vdit_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic                r_cmp_valid, n_cmp_valid;
    logic                r_cmp_last, n_cmp_last;
    logic [IDX_W-1:0]    r_cmp_addr, n_cmp_addr;
    logic                r_hit, n_hit;
    logic [IDX_W-1:0]    r_hit_idx, n_hit_idx;
    t_vertex             r_key;
    logic                r_out_valid;
    logic [OUT_IDX_W-1:0] r_out_idx, n_out_idx;
    logic                r_out_new, n_out_new;
    logic                r_out_full, n_out_full;

    logic                in_fire;
    logic                out_free;
    logic                load_out;
    logic                mem_rd_en;
    logic                mem_wr_en;
    t_vertex             mem_rd_data;
    logic                is_full;

    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign is_full  = (r_count == CNT_FULL);

    vdit_vertex_mem #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (r_key),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_rd_ptr[IDX_W-1:0]),
        .o_rd_data (mem_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cmp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_valid <= n_cmp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr   <= n_rd_ptr;
        r_cmp_last <= n_cmp_last;
        r_cmp_addr <= n_cmp_addr;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        if (in_fire) begin
            r_key <= t_vertex'(i_s_axis_tdata[VERT_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (mem_wr_en) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_idx  <= n_out_idx;
            r_out_new  <= n_out_new;
            r_out_full <= n_out_full;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_rd_ptr    = r_rd_ptr;
        n_cmp_valid = 1'b0;
        n_cmp_last  = r_cmp_last;
        n_cmp_addr  = r_cmp_addr;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_out_idx   = r_out_idx;
        n_out_new   = r_out_new;
        n_out_full  = r_out_full;
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        load_out    = 1'b0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (in_fire) begin
                    n_rd_ptr = '0;
                    n_hit    = 1'b0;
                    n_state  = (r_count == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_ptr < r_count) begin
                    mem_rd_en   = 1'b1;
                    n_rd_ptr    = r_rd_ptr + CNT_W'(1);
                    n_cmp_valid = 1'b1;
                    n_cmp_last  = ((r_rd_ptr + CNT_W'(1)) == r_count);
                    n_cmp_addr  = r_rd_ptr[IDX_W-1:0];
                end
                if (r_cmp_valid && (mem_rd_data == r_key)) begin
                    n_hit       = 1'b1;
                    n_hit_idx   = r_cmp_addr;
                    n_cmp_valid = 1'b0;
                    n_state     = ST_FINISH;
                end else if (r_cmp_valid && r_cmp_last) begin
                    n_cmp_valid = 1'b0;
                    n_state     = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (r_hit) begin
                    n_out_idx  = OUT_IDX_W'(r_hit_idx);
                    n_out_new  = 1'b0;
                    n_out_full = 1'b0;
                end else if (is_full) begin
                    n_out_idx  = '0;
                    n_out_new  = 1'b0;
                    n_out_full = 1'b1;
                end else begin
                    n_out_idx  = OUT_IDX_W'(r_count[IDX_W-1:0]);
                    n_out_new  = 1'b1;
                    n_out_full = 1'b0;
                end
                if (out_free) begin
                    load_out  = 1'b1;
                    mem_wr_en = !r_hit && !is_full;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_idx;
    assign o_m_axis_tuser[0] = r_out_new;
    assign o_m_axis_tuser[1] = r_out_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("unique count above table depth");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("is_new and table_full both set");

    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr_en |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("append did not advance unique count");

    a_compare_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_valid |-> (r_state == ST_SCAN))
        else $error("compare pending outside scan");

endmodule
